### rtl/core/nptr_pkg.sv
// Shared constants, register indexes and types of the nearest point search.
// Depends on nothing; imported by every module of the block.
package nptr_pkg;

    localparam int COORD_BITS = 16;
    localparam int LIMIT_BITS = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int DIST_BITS  = 2 * LIMIT_BITS + 1;
    localparam int ROOT_BITS  = (DIST_BITS + 1) / 2;
    localparam int VAL_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int STEP_BITS  = $clog2(ROOT_BITS);
    localparam int CFG_ADDR_BITS = 2;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [CFG_ADDR_BITS-1:0] REG_REF_X       = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REF_Y       = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REF_Z       = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_LIMIT = 2'd3;

    typedef struct packed {
        logic [DIST_BITS-1:0]         dist_sq;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         found;
    } t_frame_res;

endpackage

### rtl/core/nptr_front.sv
// Front: configuration registers, distance pipeline and running minimum.
// Pushes one frame result per last point into the queue. Uses nptr_pkg.
module nptr_front import nptr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [LIMIT_BITS-1:0]        i_cfg_data,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic                         i_point_valid,
    input  logic                         i_frame_last,
    output logic                         o_q_push,
    output t_frame_res                   o_q_data,
    input  logic                         i_q_full
);

    logic signed [COORD_BITS-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic [LIMIT_BITS-1:0]        r_start_limit;
    logic [DIST_BITS-1:0]         r_limit_sq;

    logic                         r_s1_valid, r_s2_valid, r_s3_valid;
    logic                         r_s1_pv, r_s2_pv, r_s3_pv;
    logic                         r_s1_last, r_s2_last, r_s3_last;
    logic signed [COORD_BITS-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic signed [COORD_BITS-1:0] r_s2_x, r_s2_y, r_s2_z;
    logic signed [COORD_BITS-1:0] r_s3_x, r_s3_y, r_s3_z;
    logic signed [DIFF_BITS-1:0]  r_dx, r_dy, r_dz;
    logic [SQ_BITS-1:0]           r_sqx, r_sqy, r_sqz;
    logic [SUM_BITS-1:0]          r_sum;

    logic [DIST_BITS-1:0]         r_best;
    logic signed [COORD_BITS-1:0] r_bx, r_by, r_bz;
    logic                         r_found;

    logic                         stall, advance, better, n_found;
    logic signed [DIFF_BITS-1:0]  dx, dy, dz;
    logic signed [2*DIFF_BITS-1:0] px2, py2, pz2;
    logic [2*LIMIT_BITS-1:0]      lim2;
    logic [DIST_BITS-1:0]         eff, d2, n_dist;
    logic signed [COORD_BITS-1:0] n_x, n_y, n_z;

    assign stall   = r_s3_valid && r_s3_last && i_q_full;
    assign advance = !stall;
    assign o_full  = stall;

    assign dx = DIFF_BITS'(i_point_x) - DIFF_BITS'(r_ref_x);
    assign dy = DIFF_BITS'(i_point_y) - DIFF_BITS'(r_ref_y);
    assign dz = DIFF_BITS'(i_point_z) - DIFF_BITS'(r_ref_z);
    assign px2 = r_dx * r_dx;
    assign py2 = r_dy * r_dy;
    assign pz2 = r_dz * r_dz;
    assign lim2 = r_start_limit * r_start_limit;

    assign eff    = r_found ? r_best : r_limit_sq;
    assign d2     = DIST_BITS'(r_sum);
    assign better = r_s3_pv && (d2 < eff);
    assign n_dist = better ? d2 : eff;
    assign n_x    = better ? r_s3_x : r_bx;
    assign n_y    = better ? r_s3_y : r_by;
    assign n_z    = better ? r_s3_z : r_bz;
    assign n_found = r_found || better;

    assign o_q_push         = r_s3_valid && r_s3_last && !i_q_full;
    assign o_q_data.dist_sq = n_dist;
    assign o_q_data.x       = n_x;
    assign o_q_data.y       = n_y;
    assign o_q_data.z       = n_z;
    assign o_q_data.found   = n_found;

    always_ff @(posedge i_clk) begin
        r_limit_sq <= DIST_BITS'(lim2);
        if (!i_rst_n) begin
            r_ref_x       <= '0;
            r_ref_y       <= '0;
            r_ref_z       <= '0;
            r_start_limit <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_REF_X:       r_ref_x <= i_cfg_data[COORD_BITS-1:0];
                REG_REF_Y:       r_ref_y <= i_cfg_data[COORD_BITS-1:0];
                REG_REF_Z:       r_ref_z <= i_cfg_data[COORD_BITS-1:0];
                REG_START_LIMIT: r_start_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_found    <= 1'b0;
            r_bx       <= '0;
            r_by       <= '0;
            r_bz       <= '0;
        end else if (advance) begin
            r_s1_valid <= i_push;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (r_s3_valid) begin
                if (r_s3_last) begin
                    r_found <= 1'b0;
                    r_bx    <= '0;
                    r_by    <= '0;
                    r_bz    <= '0;
                end else begin
                    r_found <= n_found;
                    r_bx    <= n_x;
                    r_by    <= n_y;
                    r_bz    <= n_z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_pv   <= i_point_valid;
            r_s1_last <= i_frame_last;
            r_s1_x    <= i_point_x;
            r_s1_y    <= i_point_y;
            r_s1_z    <= i_point_z;
            r_dx      <= dx;
            r_dy      <= dy;
            r_dz      <= dz;
            r_s2_pv   <= r_s1_pv;
            r_s2_last <= r_s1_last;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_z    <= r_s1_z;
            r_sqx     <= px2[SQ_BITS-1:0];
            r_sqy     <= py2[SQ_BITS-1:0];
            r_sqz     <= pz2[SQ_BITS-1:0];
            r_s3_pv   <= r_s2_pv;
            r_s3_last <= r_s2_last;
            r_s3_x    <= r_s2_x;
            r_s3_y    <= r_s2_y;
            r_s3_z    <= r_s2_z;
            r_sum     <= SUM_BITS'(r_sqx) + SUM_BITS'(r_sqy) + SUM_BITS'(r_sqz);
            if (r_s3_valid) begin
                r_best <= n_dist;
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> r_s3_valid && r_s3_last)
        else $error("stalled last point lost");
    a_idle_coords_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> (r_bx == 0 && r_by == 0 && r_bz == 0))
        else $error("nearest point not cleared while nothing found");
`endif

endmodule

### rtl/core/nptr_fifo.sv
// Short queue of frame results between the search front and the root back.
// Register array with read and write pointers. Uses nptr_pkg.
module nptr_fifo import nptr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_res i_data,
    output logic       o_full,
    input  logic       i_pop,
    output t_frame_res o_data,
    output logic       o_empty
);

    t_frame_res                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_PTR_BITS:0]    r_count;
    logic                      do_push, do_pop;

    assign o_full  = (r_count == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (FIFO_PTR_BITS+1)'(do_push) - (FIFO_PTR_BITS+1)'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH))
        else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_rd_ptr == r_wr_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/core/nptr_back.sv
// Back: takes frame results from the queue, runs a two-bits-per-cycle
// integer square root and holds the result in the output register. Uses nptr_pkg.
module nptr_back import nptr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_frame_res                   i_q_data,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [LIMIT_BITS-1:0]        o_near_dist,
    output logic signed [COORD_BITS-1:0] o_nearest_x,
    output logic signed [COORD_BITS-1:0] o_nearest_y,
    output logic signed [COORD_BITS-1:0] o_nearest_z,
    output logic                         o_found
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state                       r_state;
    logic [VAL_BITS-1:0]          r_val;
    logic [REM_BITS-1:0]          r_rem;
    logic [ROOT_BITS-1:0]         r_root;
    logic [STEP_BITS-1:0]         r_cnt;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic                         r_fnd;
    logic                         r_out_valid;

    logic [REM_BITS:0]            rem_sh, trial, rem_sub;
    logic                         ge;

    assign rem_sh  = {r_rem[REM_BITS-2:0], r_val[VAL_BITS-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_val   <= VAL_BITS'(i_q_data.dist_sq);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_x     <= i_q_data.x;
                        r_y     <= i_q_data.y;
                        r_z     <= i_q_data.z;
                        r_fnd   <= i_q_data.found;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_val  <= {r_val[VAL_BITS-3:0], 2'b00};
                    r_rem  <= ge ? rem_sub[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
                    r_root <= {r_root[ROOT_BITS-2:0], ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == STEP_BITS'(ROOT_BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_pop) begin
                        o_near_dist <= r_root[LIMIT_BITS-1:0];
                        o_nearest_x <= r_x;
                        o_nearest_y <= r_y;
                        o_nearest_z <= r_z;
                        o_found     <= r_fnd;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt < STEP_BITS'(ROOT_BITS)))
        else $error("root step counter out of range");
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown before root finished");
`endif

endmodule

### rtl/core/nearest_point_to_reference_top.sv
// Top level of the nearest point search: front, result queue and root back.
// Depends on nptr_pkg, nptr_front, nptr_fifo and nptr_back.
//
// Usage:
//   Points enter on a queue-style input: a transaction completes at a rising
//   edge with push high and full low; one point per cycle while not full.
//   A point with frame_last closes its frame; one result transaction per
//   frame comes out on the result side: the result is on the ports while
//   empty is low and is taken at an edge with pop high.
//   From the last point of a frame to its result, the frame passes the
//   distance pipeline into the queue, the root unit loads it and runs 18
//   root steps, then loads the output when free. The root unit takes
//   a new frame only when idle; a two-entry queue holds finished frames.
//   Registers are written through i_cfg_we / i_cfg_addr / i_cfg_data while
//   the block is idle; reference writes take effect on the next cycle.
//   Reset (synchronous, active low) sets the reference to the origin and
//   the start limit to all ones, and drops queued and shown results.
//   When the receiver stalls, the shown result holds, frames collect in the
//   queue, and full rises once a last point finds the queue full.
module nearest_point_to_reference_top import nptr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [LIMIT_BITS-1:0]        i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic                         i_point_valid,
    input  logic                         i_frame_last,
    output logic                         empty,
    input  logic                         pop,
    output logic [LIMIT_BITS-1:0]        o_near_dist,
    output logic signed [COORD_BITS-1:0] o_nearest_x,
    output logic signed [COORD_BITS-1:0] o_nearest_y,
    output logic signed [COORD_BITS-1:0] o_nearest_z,
    output logic                         o_found
);

    logic       q_push, q_full, q_pop, q_empty;
    t_frame_res q_wdata, q_rdata;

    nptr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .o_full        (full),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_point_valid (i_point_valid),
        .i_frame_last  (i_frame_last),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata),
        .i_q_full      (q_full)
    );

    nptr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    nptr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_near_dist (o_near_dist),
        .o_nearest_x (o_nearest_x),
        .o_nearest_y (o_nearest_y),
        .o_nearest_z (o_nearest_z),
        .o_found     (o_found)
    );

endmodule
